// ----- rtl/core/tsae_pkg.sv -----
// ----------------------------------------------------------------------------
// tsae_pkg
// Request codes and fixed field widths for the two-set algebra engine.
// ----------------------------------------------------------------------------
package tsae_pkg;

   localparam int KIND_W      = 3;
   localparam int VALUE_W     = 32;
   localparam int MAX_RESULTS = 32;
   localparam int OUT_CNT_W   = $clog2(MAX_RESULTS);

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD_A   = 3'd0,
      KIND_ADD_B   = 3'd1,
      KIND_CLEAR   = 3'd2,
      KIND_UNION   = 3'd3,
      KIND_DIFF    = 3'd4,
      KIND_INTER   = 3'd5,
      KIND_COMPARE = 3'd6
   } kind_type;

endpackage

// ----- rtl/core/two_set_algebra_engine.sv -----
// ----------------------------------------------------------------------------
// two_set_algebra_engine
// Two bounded insertion-ordered sets with add, clear, union, difference,
// intersection and compare requests, kept in two single-port-read memories.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. busy stays high
//   until the last response of that request has been driven.
//   Each response is on the rsp_ ports for one cycle while rsp_valid is high;
//   the receiver cannot stall, so responses are never held back.
//   Add A/B: one response; busy while one comparator scans the target
//   memory, one entry a cycle.
//   Clear: no response, takes effect at once, busy never rises.
//   Union/difference/intersection: each outer element is read, latched and
//   decided on, with a membership scan of the other memory between latch
//   and decision (a hit ends it early); union's first pass has no scan.
//   Results stream in order with last on the final one; an empty result
//   gives one response with element_valid low. At most 32 responses.
//   Compare: two nested scans (A in B, then B in A), a miss ends a pass;
//   one response at the end.
//   Reset clears both counts; the stores need no clearing pass.
// ----------------------------------------------------------------------------
module two_set_algebra_engine #(
   parameter int SET_CAPACITY = 16,
   parameter int DATA_WIDTH   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tsae_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [tsae_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   output logic signed [tsae_pkg::VALUE_W-1:0] rsp_element,
   output logic                                rsp_element_valid,
   output logic                                rsp_last,
   output logic                                rsp_added,
   output logic                                rsp_full_res,
   output logic                                rsp_equal,
   output logic                                rsp_proper_superset,
   output logic                                rsp_proper_subset,
   output logic                                rsp_superset,
   output logic                                rsp_subset
);

   localparam int CNT_W = $clog2(SET_CAPACITY + 1);
   localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int EW    = tsae_pkg::VALUE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OUTER,
      S_OLATCH,
      S_SCAN,
      S_NEXT
   } state_type;

   state_type                        state_ff;
   tsae_pkg::kind_type               op_ff;
   logic                             phase_ff;
   logic [CNT_W-1:0]                 cnt_a_ff, cnt_b_ff;
   logic [CNT_W-1:0]                 outer_ff, scan_ff;
   logic                             rd_pend_ff;
   logic                             hit_ff;
   logic [DATA_WIDTH-1:0]            probe_ff;
   logic [DATA_WIDTH-1:0]            held_ff;
   logic                             held_vld_ff;
   logic [tsae_pkg::OUT_CNT_W-1:0]   out_cnt_ff;
   logic                             a_in_b_ff, b_in_a_ff;

   logic                             rsp_valid_ff, rsp_elem_vld_ff, rsp_last_ff;
   logic                             rsp_added_ff, rsp_full_ff;
   logic                             rsp_equal_ff, rsp_psuper_ff, rsp_psub_ff;
   logic                             rsp_super_ff, rsp_sub_ff;
   logic [EW-1:0]                    rsp_elem_ff;

   logic [DATA_WIDTH-1:0]            set_a_mem [SET_CAPACITY];
   logic [DATA_WIDTH-1:0]            set_b_mem [SET_CAPACITY];
   logic [DATA_WIDTH-1:0]            rd_a_ff, rd_b_ff;

   logic                             outer_is_b, inner_is_a, no_inner;
   logic [CNT_W-1:0]                 outer_cnt, inner_cnt;
   logic [IDX_W-1:0]                 addr_a, addr_b;
   logic [DATA_WIDTH-1:0]            outer_data, inner_data;
   logic                             match;
   logic                             inner_full;
   logic                             wr_a, wr_b;
   logic                             emit;
   logic [DATA_WIDTH+EW-1:0]         held_wide;
   logic [DATA_WIDTH+EW-1:0]         value_wide;

   // operand routing for the current request and pass
   always_comb begin
      outer_is_b = phase_ff &&
                   (op_ff inside {tsae_pkg::KIND_UNION, tsae_pkg::KIND_COMPARE});
      inner_is_a = (op_ff == tsae_pkg::KIND_ADD_A) || outer_is_b;
      no_inner   = (op_ff == tsae_pkg::KIND_UNION) && !phase_ff;
      outer_cnt  = outer_is_b ? cnt_b_ff : cnt_a_ff;
      inner_cnt  = inner_is_a ? cnt_a_ff : cnt_b_ff;
      addr_a     = inner_is_a ? scan_ff[IDX_W-1:0] : outer_ff[IDX_W-1:0];
      addr_b     = inner_is_a ? outer_ff[IDX_W-1:0] : scan_ff[IDX_W-1:0];
      outer_data = outer_is_b ? rd_b_ff : rd_a_ff;
      inner_data = inner_is_a ? rd_a_ff : rd_b_ff;
      match      = rd_pend_ff && (inner_data == probe_ff);
      inner_full = (inner_cnt >= CNT_W'(SET_CAPACITY));
      wr_a       = (state_ff == S_NEXT) && (op_ff == tsae_pkg::KIND_ADD_A) &&
                   !hit_ff && !inner_full;
      wr_b       = (state_ff == S_NEXT) && (op_ff == tsae_pkg::KIND_ADD_B) &&
                   !hit_ff && !inner_full;
      emit       = no_inner ||
                   ((op_ff == tsae_pkg::KIND_INTER) ? hit_ff : !hit_ff);
   end

   assign held_wide  = {{EW{1'b0}}, held_ff};
   assign value_wide = {{DATA_WIDTH{1'b0}}, req_value};

   // set memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (wr_a) begin
         set_a_mem[cnt_a_ff[IDX_W-1:0]] <= probe_ff;
      end
      rd_a_ff <= set_a_mem[addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         set_b_mem[cnt_b_ff[IDX_W-1:0]] <= probe_ff;
      end
      rd_b_ff <= set_b_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         op_ff           <= tsae_pkg::KIND_CLEAR;
         phase_ff        <= 1'b0;
         cnt_a_ff        <= '0;
         cnt_b_ff        <= '0;
         outer_ff        <= '0;
         scan_ff         <= '0;
         rd_pend_ff      <= 1'b0;
         hit_ff          <= 1'b0;
         held_vld_ff     <= 1'b0;
         out_cnt_ff      <= '0;
         a_in_b_ff       <= 1'b0;
         b_in_a_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_elem_vld_ff <= 1'b0;
         rsp_last_ff     <= 1'b0;
         rsp_added_ff    <= 1'b0;
         rsp_full_ff     <= 1'b0;
         rsp_equal_ff    <= 1'b0;
         rsp_psuper_ff   <= 1'b0;
         rsp_psub_ff     <= 1'b0;
         rsp_super_ff    <= 1'b0;
         rsp_sub_ff      <= 1'b0;
         rsp_elem_ff     <= '0;
      end else begin
         // drop the strobe and clear the response fields by default
         rsp_valid_ff    <= 1'b0;
         rsp_elem_vld_ff <= 1'b0;
         rsp_last_ff     <= 1'b0;
         rsp_added_ff    <= 1'b0;
         rsp_full_ff     <= 1'b0;
         rsp_equal_ff    <= 1'b0;
         rsp_psuper_ff   <= 1'b0;
         rsp_psub_ff     <= 1'b0;
         rsp_super_ff    <= 1'b0;
         rsp_sub_ff      <= 1'b0;
         rsp_elem_ff     <= '0;
         if (wr_a) begin
            cnt_a_ff <= cnt_a_ff + CNT_W'(1);
         end
         if (wr_b) begin
            cnt_b_ff <= cnt_b_ff + CNT_W'(1);
         end

         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  case (req_kind)
                     tsae_pkg::KIND_ADD_A, tsae_pkg::KIND_ADD_B: begin
                        op_ff      <= tsae_pkg::kind_type'(req_kind);
                        phase_ff   <= 1'b0;
                        probe_ff   <= value_wide[DATA_WIDTH-1:0];
                        scan_ff    <= '0;
                        rd_pend_ff <= 1'b0;
                        state_ff   <= S_SCAN;
                     end
                     tsae_pkg::KIND_CLEAR: begin
                        cnt_a_ff <= '0;
                        cnt_b_ff <= '0;
                     end
                     tsae_pkg::KIND_UNION, tsae_pkg::KIND_DIFF,
                     tsae_pkg::KIND_INTER, tsae_pkg::KIND_COMPARE: begin
                        op_ff       <= tsae_pkg::kind_type'(req_kind);
                        phase_ff    <= 1'b0;
                        outer_ff    <= '0;
                        held_vld_ff <= 1'b0;
                        out_cnt_ff  <= '0;
                        a_in_b_ff   <= 1'b1;
                        b_in_a_ff   <= 1'b1;
                        state_ff    <= S_OUTER;
                     end
                     default: begin
                     end
                  endcase
               end
            end

            S_OUTER: begin
               if (outer_ff == outer_cnt) begin
                  // end of a pass over the outer set
                  if ((op_ff inside {tsae_pkg::KIND_UNION, tsae_pkg::KIND_COMPARE}) &&
                      !phase_ff) begin
                     phase_ff <= 1'b1;
                     outer_ff <= '0;
                  end else if (op_ff == tsae_pkg::KIND_COMPARE) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_last_ff   <= 1'b1;
                     rsp_equal_ff  <= (cnt_a_ff == cnt_b_ff) && a_in_b_ff;
                     rsp_sub_ff    <= (cnt_a_ff <= cnt_b_ff) && a_in_b_ff;
                     rsp_super_ff  <= (cnt_a_ff >= cnt_b_ff) && b_in_a_ff;
                     rsp_psub_ff   <= (cnt_a_ff < cnt_b_ff) && a_in_b_ff;
                     rsp_psuper_ff <= (cnt_a_ff > cnt_b_ff) && b_in_a_ff;
                     state_ff      <= S_IDLE;
                  end else begin
                     // flush the held element, or an empty marker
                     rsp_valid_ff    <= 1'b1;
                     rsp_last_ff     <= 1'b1;
                     rsp_elem_vld_ff <= held_vld_ff;
                     rsp_elem_ff     <= held_vld_ff ? held_wide[EW-1:0] : '0;
                     held_vld_ff     <= 1'b0;
                     state_ff        <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_OLATCH;
               end
            end

            S_OLATCH: begin
               probe_ff   <= outer_data;
               scan_ff    <= '0;
               rd_pend_ff <= 1'b0;
               hit_ff     <= 1'b0;
               state_ff   <= no_inner ? S_NEXT : S_SCAN;
            end

            S_SCAN: begin
               if (match) begin
                  hit_ff     <= 1'b1;
                  rd_pend_ff <= 1'b0;
                  state_ff   <= S_NEXT;
               end else if (scan_ff >= inner_cnt) begin
                  hit_ff     <= 1'b0;
                  rd_pend_ff <= 1'b0;
                  state_ff   <= S_NEXT;
               end else begin
                  scan_ff    <= scan_ff + CNT_W'(1);
                  rd_pend_ff <= 1'b1;
               end
            end

            S_NEXT: begin
               if (op_ff inside {tsae_pkg::KIND_ADD_A, tsae_pkg::KIND_ADD_B}) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= 1'b1;
                  rsp_added_ff <= !hit_ff && !inner_full;
                  rsp_full_ff  <= !hit_ff && inner_full;
                  state_ff     <= S_IDLE;
               end else if (op_ff == tsae_pkg::KIND_COMPARE) begin
                  if (!hit_ff) begin
                     // one miss settles this direction; skip the rest of the pass
                     if (phase_ff) begin
                        b_in_a_ff <= 1'b0;
                     end else begin
                        a_in_b_ff <= 1'b0;
                     end
                     outer_ff <= outer_cnt;
                  end else begin
                     outer_ff <= outer_ff + CNT_W'(1);
                  end
                  state_ff <= S_OUTER;
               end else if (emit && held_vld_ff &&
                            (out_cnt_ff == tsae_pkg::OUT_CNT_W'(tsae_pkg::MAX_RESULTS - 1))) begin
                  // stream limit reached: the held element closes it
                  rsp_valid_ff    <= 1'b1;
                  rsp_last_ff     <= 1'b1;
                  rsp_elem_vld_ff <= 1'b1;
                  rsp_elem_ff     <= held_wide[EW-1:0];
                  held_vld_ff     <= 1'b0;
                  state_ff        <= S_IDLE;
               end else begin
                  if (emit) begin
                     if (held_vld_ff) begin
                        rsp_valid_ff    <= 1'b1;
                        rsp_elem_vld_ff <= 1'b1;
                        rsp_elem_ff     <= held_wide[EW-1:0];
                        out_cnt_ff      <= out_cnt_ff + tsae_pkg::OUT_CNT_W'(1);
                     end
                     held_ff     <= probe_ff;
                     held_vld_ff <= 1'b1;
                  end
                  outer_ff <= outer_ff + CNT_W'(1);
                  state_ff <= S_OUTER;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_element         = rsp_elem_ff;
   assign rsp_element_valid   = rsp_elem_vld_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_added           = rsp_added_ff;
   assign rsp_full_res        = rsp_full_ff;
   assign rsp_equal           = rsp_equal_ff;
   assign rsp_proper_superset = rsp_psuper_ff;
   assign rsp_proper_subset   = rsp_psub_ff;
   assign rsp_superset        = rsp_super_ff;
   assign rsp_subset          = rsp_sub_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= CNT_W'(SET_CAPACITY)) && (cnt_b_ff <= CNT_W'(SET_CAPACITY)))
      else $error("set count above capacity");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      (wr_a || wr_b) |-> !(wr_a && wr_b) && !inner_full)
      else $error("store write without room");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff != S_IDLE))
      else $error("response without an active request");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == S_IDLE))
      else $error("last response while request still active");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == S_SCAN))
      else $error("scan read pending outside scan");

endmodule
